// File: src/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, codes and controller/datapath interface types for the
// bitmap fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

  localparam int ENTRIES = 1024;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KIND_W  = 2;
  localparam int FIT_W   = 2;
  localparam int ACT_W   = 11;
  localparam int CFG_W   = 11;
  localparam int REGI_W  = 1;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_USE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

  localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;

  localparam logic [REGI_W-1:0] REG_FIT_MODE = 1'd0;
  localparam logic [REGI_W-1:0] REG_ACTIVE   = 1'd1;

  localparam logic [FIT_W-1:0] FIT_MODE_RESET = FIT_FIRST;
  localparam logic [ACT_W-1:0] ACTIVE_RESET   = ACT_W'(ENTRIES);

  typedef struct packed {
    logic clr_step;
    logic latch_in;
    logic scan_start;
    logic do_mark;
    logic do_commit;
    logic set_fail;
    logic load_out;
  } bfa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic is_mark;
    logic mark_ok;
    logic n_zero;
    logic scan_done;
    logic out_free;
  } bfa_status_t;

endpackage

`default_nettype wire

// File: src/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/bfa_datapath.sv
// ----------------------------------------------------------------------------
// bfa_datapath
// Bitmap store, configuration registers, scan counter, run tracking and the
// output register of the bitmap fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  bfa_pkg::bfa_cmd_t            cmd,
  output bfa_pkg::bfa_status_t         status,
  input  logic                         cfg_we,
  input  logic [bfa_pkg::REGI_W-1:0]   cfg_index,
  input  logic [bfa_pkg::CFG_W-1:0]    cfg_data,
  input  logic [bfa_pkg::KIND_W-1:0]   kind,
  input  logic [bfa_pkg::IDX_W-1:0]    entry_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         ok,
  output logic [bfa_pkg::IDX_W-1:0]    found_index
);

  import bfa_pkg::*;

  logic [FIT_W-1:0]  fit_mode;
  logic [ACT_W-1:0]  active_entries;
  logic [CNT_W-1:0]  n_act;

  logic [KIND_W-1:0] item_kind;
  logic [IDX_W-1:0]  item_idx;

  logic [IDX_W-1:0]  clr_cnt;
  logic [IDX_W-1:0]  rd_addr;
  logic              issuing;
  logic              proc_valid;
  logic [IDX_W-1:0]  proc_idx;
  logic              rd_bit;
  logic              proc_last;

  logic [CNT_W-1:0]  run_len, run_len_next;
  logic [IDX_W-1:0]  run_start, run_start_next;
  logic [CNT_W-1:0]  best_len, best_len_next;
  logic [IDX_W-1:0]  best_start, best_start_next;

  logic              res_ok;
  logic [IDX_W-1:0]  res_idx;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic              ram_wdata;

  logic              fit_runs;
  logic              bit_free;
  logic [CNT_W-1:0]  run_cur;
  logic [IDX_W-1:0]  start_cur;
  logic              run_close;
  logic              take;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode       <= FIT_MODE_RESET;
      active_entries <= ACTIVE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIT_MODE: fit_mode       <= cfg_data[FIT_W-1:0];
        REG_ACTIVE:   active_entries <= cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_act = (active_entries > ACT_W'(ENTRIES)) ? CNT_W'(ENTRIES)
                                                    : CNT_W'(active_entries);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      item_kind <= kind;
      item_idx  <= entry_index;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // read issue and processing alignment
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing    <= 1'b0;
      proc_valid <= 1'b0;
    end else begin
      proc_valid <= issuing;
      if (cmd.scan_start) begin
        issuing <= 1'b1;
      end else if (issuing && ({1'b0, rd_addr} == n_act - 1'b1)) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= rd_addr;
    if (cmd.scan_start) begin
      rd_addr <= '0;
    end else if (issuing) begin
      rd_addr <= rd_addr + 1'b1;
    end
  end

  assign proc_last = proc_valid && ({1'b0, proc_idx} == n_act - 1'b1);
  assign fit_runs  = (fit_mode == FIT_BEST) || (fit_mode == FIT_WORST);

  // run tracking
  always_comb begin
    bit_free        = !rd_bit;
    run_cur         = bit_free ? run_len + 1'b1 : run_len;
    start_cur       = (bit_free && run_len == '0) ? proc_idx : run_start;
    run_close       = rd_bit || proc_last;
    take            = 1'b0;
    run_len_next    = run_len;
    run_start_next  = run_start;
    best_len_next   = best_len;
    best_start_next = best_start;
    if (proc_valid) begin
      if (fit_runs) begin
        if (run_close && run_cur != '0) begin
          if (best_len == '0) begin
            take = 1'b1;
          end else if (fit_mode == FIT_BEST) begin
            take = run_cur < best_len;
          end else begin
            take = run_cur > best_len;
          end
        end
        run_len_next   = run_close ? '0 : run_cur;
        run_start_next = start_cur;
        if (take) begin
          best_len_next   = run_cur;
          best_start_next = start_cur;
        end
      end else if (bit_free && best_len == '0) begin
        best_len_next   = CNT_W'(1);
        best_start_next = proc_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      run_len    <= '0;
      run_start  <= '0;
      best_len   <= '0;
      best_start <= '0;
    end else begin
      run_len    <= run_len_next;
      run_start  <= run_start_next;
      best_len   <= best_len_next;
      best_start <= best_start_next;
    end
  end

  // bitmap write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = item_idx;
    ram_wdata = 1'b0;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
    end else if (cmd.do_mark) begin
      ram_we    = 1'b1;
      ram_wdata = (item_kind == KIND_USE);
    end else if (cmd.do_commit) begin
      ram_we    = (best_len != '0);
      ram_waddr = best_start;
      ram_wdata = 1'b1;
    end
  end

  bfa_ram #(
    .WIDTH (1),
    .DEPTH (ENTRIES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rd_bit)
  );

  // result and output registers
  always_ff @(posedge clk) begin
    if (cmd.do_mark) begin
      res_ok  <= 1'b1;
      res_idx <= item_idx;
    end else if (cmd.do_commit) begin
      res_ok  <= (best_len != '0);
      res_idx <= (best_len != '0) ? best_start : '0;
    end else if (cmd.set_fail) begin
      res_ok  <= 1'b0;
      res_idx <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ok          <= res_ok;
      found_index <= res_idx;
    end
  end

  assign status.clr_last  = (clr_cnt == IDX_W'(ENTRIES - 1));
  assign status.is_alloc  = (item_kind == KIND_ALLOC);
  assign status.is_mark   = (item_kind == KIND_USE) || (item_kind == KIND_FREE);
  assign status.mark_ok   = ({1'b0, item_idx} < n_act);
  assign status.n_zero    = (n_act == '0);
  assign status.scan_done = proc_last;
  assign status.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

// File: src/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer of the bitmap fit allocator: clearing pass, item decode, scan,
// commit and hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output bfa_pkg::bfa_cmd_t     cmd,
  input  bfa_pkg::bfa_status_t  status
);

  import bfa_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
        if (in_valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        if (status.is_alloc && !status.n_zero) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else if (status.is_mark && status.mark_ok) begin
          cmd.do_mark = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.set_fail = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_SCAN: begin
        if (status.scan_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.do_commit = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/bitmap_fit_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_fit_allocator
// Free/used bitmap over the active entries with first, best and worst fit
// allocation and single-entry mark-used / mark-free items.
//
// Input channel (in_valid/in_ready) carries kind and entry_index; one result
// beat (ok, found_index) leaves on out_valid/out_ready for every input beat.
// Items are handled one at a time. An allocate item scans the active entries
// one per cycle through the bitmap RAM read port, all n of them, n being the
// active count (up to 1024 entries), whatever the fit.
// Configuration (fit_mode, active_entries) is written on cfg_we with
// cfg_index/cfg_data; the user must do so only while the block is idle,
// which the block itself does not enforce.
// After reset the bitmap RAM is cleared one entry per cycle over all 1024
// entries, while in_ready is low; configuration writes are still taken.
// A stalled receiver holds the result in the output register; the block
// finishes the current item and waits there before taking another.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_fit_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bfa_pkg::REGI_W-1:0]  cfg_index,
  input  logic [bfa_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bfa_pkg::KIND_W-1:0]  kind,
  input  logic [bfa_pkg::IDX_W-1:0]   entry_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        ok,
  output logic [bfa_pkg::IDX_W-1:0]   found_index
);

  import bfa_pkg::*;

  bfa_cmd_t    cmd;
  bfa_status_t status;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  bfa_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .kind        (kind),
    .entry_index (entry_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .found_index (found_index)
  );

endmodule

`default_nettype wire

// File: src/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the bitmap fit allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        ok,
  input logic [bfa_pkg::IDX_W-1:0]   found_index
);

  import bfa_pkg::*;

  // clearing pass blocks input right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken during clearing pass");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in flight");

  // failure carries index zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (found_index == '0))
    else $error("failed result with non-zero index");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(ok) && $stable(found_index)))
    else $error("result beat changed under stall");

endmodule

bind bitmap_fit_allocator bfa_checker u_bfa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .ok          (ok),
  .found_index (found_index)
);

`default_nettype wire
